>>> rtl/core/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared constants, codes and controller/datapath command types for the
// matrix multiply engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

  localparam int MAX_DIM       = 8;
  localparam int VALUE_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;

  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PROD_W = 2 * VALUE_WIDTH;
  localparam int ACC_W  = 64;

  // fixed field widths of the ports
  localparam int OP_W      = 2;
  localparam int IDX_W     = 3;
  localparam int ELEM_W    = 32;
  localparam int CFG_W     = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(8);

  localparam logic [OP_W-1:0] OP_WRITE_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_MULTIPLY = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLS_B     = 2'd2;

  typedef struct packed {
    logic                   wr_a;
    logic                   wr_b;
    logic [ADDR_W-1:0]      wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr_a;
    logic [ADDR_W-1:0]      rd_addr_b;
    logic                   first;
    logic                   last;
  } mme_cmd_t;

  typedef struct packed {
    logic done;
  } mme_status_t;

endpackage

`default_nettype wire

>>> rtl/core/mme_if.sv
// ----------------------------------------------------------------------------
// mme_if
// Valid/ready channels of the matrix multiply engine: command words in,
// result words out, configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mme_in_if;
  import mme_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [ELEM_W-1:0] elem_value;

  modport source (output valid, opcode, row_index, col_index, elem_value, input ready);
  modport sink   (input valid, opcode, row_index, col_index, elem_value, output ready);
endinterface

interface mme_out_if;
  import mme_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [ELEM_W-1:0] out_value;
  logic                     out_last;

  modport source (output valid, out_row, out_col, out_value, out_last, input ready);
  modport sink   (input valid, out_row, out_col, out_value, out_last, output ready);
endinterface

interface mme_cfg_if;
  import mme_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0]     wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mme_ram.sv
// ----------------------------------------------------------------------------
// mme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/mme_ctrl.sv
// ----------------------------------------------------------------------------
// mme_ctrl
// Sequencer: configuration registers, command decode, element and inner
// index counters, result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_ctrl import mme_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  input  wire logic [REG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_W-1:0]       cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [OP_W-1:0]        opcode_i,
  input  wire logic [IDX_W-1:0]       row_index_i,
  input  wire logic [IDX_W-1:0]       col_index_i,
  input  wire logic [ELEM_W-1:0]      elem_value_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [IDX_W-1:0]            out_row_o,
  output logic [IDX_W-1:0]            out_col_o,
  output logic                        out_last_o,
  output mme_cmd_t                    cmd_o,
  input  wire mme_status_t            status_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  function automatic logic [CNT_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
    logic [CNT_W-1:0] res;
    if (r == '0) begin
      res = CNT_W'(1);
    end else if (int'(r) > MAX_DIM) begin
      res = CNT_W'(MAX_DIM);
    end else begin
      res = CNT_W'(r);
    end
    return res;
  endfunction

  logic [1:0]       state_q, state_d;
  logic [CFG_W-1:0] rows_a_q, inner_q, cols_b_q;
  logic [DIM_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [CNT_W-1:0] nr, nk, nc;
  logic             in_fire, k_last, elem_last, a_ok, b_ok;
  logic [ADDR_W-1:0] wr_addr;

  assign nr = eff_dim(rows_a_q);
  assign nk = eff_dim(inner_q);
  assign nc = eff_dim(cols_b_q);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= DIM_RESET;
      inner_q  <= DIM_RESET;
      cols_b_q <= DIM_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROWS_A:     rows_a_q <= cfg_data_i;
        REG_INNER_SIZE: inner_q  <= cfg_data_i;
        REG_COLS_B:     cols_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign a_ok = ({1'b0, row_index_i} < (IDX_W+1)'(nr)) && ({1'b0, col_index_i} < (IDX_W+1)'(nk));
  assign b_ok = ({1'b0, row_index_i} < (IDX_W+1)'(nk)) && ({1'b0, col_index_i} < (IDX_W+1)'(nc));
  assign wr_addr = ADDR_W'(int'(row_index_i) * MAX_DIM + int'(col_index_i));

  assign k_last    = (CNT_W'(k_q) == nk - CNT_W'(1));
  assign elem_last = (CNT_W'(i_q) == nr - CNT_W'(1)) && (CNT_W'(j_q) == nc - CNT_W'(1));

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;

    cmd_o           = '0;
    cmd_o.wr_addr   = wr_addr;
    cmd_o.wr_data   = elem_value_i[VALUE_WIDTH-1:0];
    cmd_o.rd_addr_a = ADDR_W'(int'(i_q) * MAX_DIM + int'(k_q));
    cmd_o.rd_addr_b = ADDR_W'(int'(k_q) * MAX_DIM + int'(j_q));
    cmd_o.first     = (k_q == '0);
    cmd_o.last      = k_last;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (opcode_i)
            OP_WRITE_A: cmd_o.wr_a = a_ok;
            OP_WRITE_B: cmd_o.wr_b = b_ok;
            OP_MULTIPLY: begin
              i_d     = '0;
              j_d     = '0;
              k_d     = '0;
              state_d = S_ISSUE;
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        cmd_o.rd_en = 1'b1;
        if (k_last) begin
          k_d     = '0;
          state_d = S_WAIT;
        end else begin
          k_d = k_q + DIM_W'(1);
        end
      end
      S_WAIT: begin
        if (status_i.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (elem_last) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_ISSUE;
            if (CNT_W'(j_q) == nc - CNT_W'(1)) begin
              j_d = '0;
              i_d = i_q + DIM_W'(1);
            end else begin
              j_d = j_q + DIM_W'(1);
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  assign out_valid_o = (state_q == S_OUT);
  assign out_row_o   = IDX_W'(i_q);
  assign out_col_o   = IDX_W'(j_q);
  assign out_last_o  = elem_last;

endmodule

`default_nettype wire

>>> rtl/core/mme_dp.sv
// ----------------------------------------------------------------------------
// mme_dp
// Datapath: operand stores, multiplier, shifting saturating accumulator and
// saturated result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_dp import mme_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mme_cmd_t         cmd_i,
  output mme_status_t           status_o,
  output logic [ELEM_W-1:0]     out_value_o
);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] V_MAX   = ACC_W'((64'sd1 <<< (VALUE_WIDTH-1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] V_MIN   = -V_MAX - ACC_W'(1);

  logic [VALUE_WIDTH-1:0]   a_data, b_data;
  logic                     s1_valid_q, s1_first_q, s1_last_q;
  logic                     s2_valid_q, s2_first_q, s2_last_q;
  logic signed [PROD_W-1:0] prod_q, prod_d, prod_sh;
  logic signed [ACC_W-1:0]  acc_q, acc_d, addend, base;
  logic signed [ACC_W:0]    sum;
  logic                     done_q;
  logic signed [ACC_W-1:0]  sat_v;
  logic signed [VALUE_WIDTH-1:0] sat_narrow;
  logic [ELEM_W-1:0]        out_value_q;

  mme_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_a),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i (cmd_i.wr_data),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr_a),
    .rdata_o (a_data)
  );

  mme_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_b),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i (cmd_i.wr_data),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr_b),
    .rdata_o (b_data)
  );

  assign prod_d  = PROD_W'($signed(a_data) * $signed(b_data));
  assign prod_sh = prod_q >>> FRACTION_BITS;
  assign addend  = ACC_W'(prod_sh);
  assign base    = s2_first_q ? '0 : acc_q;
  assign sum     = {base[ACC_W-1], base} + {addend[ACC_W-1], addend};

  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_d = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_d = sum[ACC_W-1:0];
    end
  end

  // final saturation to the value range
  always_comb begin
    if (acc_q > V_MAX) begin
      sat_v = V_MAX;
    end else if (acc_q < V_MIN) begin
      sat_v = V_MIN;
    end else begin
      sat_v = acc_q;
    end
  end
  assign sat_narrow = sat_v[VALUE_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_first_q <= 1'b0;
      s2_last_q  <= 1'b0;
      done_q     <= 1'b0;
      acc_q      <= '0;
    end else begin
      s1_valid_q <= cmd_i.rd_en;
      s1_first_q <= cmd_i.first;
      s1_last_q  <= cmd_i.last;
      s2_valid_q <= s1_valid_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      done_q     <= s2_valid_q && s2_last_q;
      if (s2_valid_q) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      prod_q <= prod_d;
    end
    if (done_q) begin
      out_value_q <= ELEM_W'(sat_narrow);
    end
  end

  assign status_o.done = done_q;
  assign out_value_o   = out_value_q;

endmodule

`default_nettype wire

>>> rtl/core/matrix_multiply_engine.sv
// each result word: inner_size MAC steps through the read, product and accumulator registers
// datapath: one MAC step per cycle on one multiplier while an element accumulates
// writes keep the input ready; no new word is taken until the last result word is delivered
// reset: asynchronous, active low; clears control, accumulator and sets all dimensions to 8
// operand stores are not cleared by reset
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Dense fixed-point matrix product C = A x B with operand stores loaded
// element by element and results emitted in row-major order.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_engine import mme_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mme_cfg_if.sink    cfg_i,
  mme_in_if.sink     in_i,
  mme_out_if.source  out_o
);

  mme_cmd_t          cmd;
  mme_status_t       status;
  logic [ELEM_W-1:0] dp_value;

  assign cfg_i.ready = 1'b1;

  mme_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_index_i  (cfg_i.reg_index),
    .cfg_data_i   (cfg_i.wdata),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .opcode_i     (in_i.opcode),
    .row_index_i  (in_i.row_index),
    .col_index_i  (in_i.col_index),
    .elem_value_i (in_i.elem_value),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_row_o    (out_o.out_row),
    .out_col_o    (out_o.out_col),
    .out_last_o   (out_o.out_last),
    .cmd_o        (cmd),
    .status_i     (status)
  );

  mme_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_value_o (dp_value)
  );

  assign out_o.out_value = dp_value;

`ifndef SYNTH
  a_no_ready_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while a result word is pending");

  a_done_not_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.done |-> !out_o.valid)
    else $error("accumulation finished while a result word is pending");

  a_no_read_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> (!out_o.valid && !in_i.ready))
    else $error("operand read outside the issue phase");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.out_last) |=> in_i.ready)
    else $error("not idle after the last result word");
`endif

endmodule

`default_nettype wire

>>> verif/tb_matrix_multiply_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix_multiply_engine
// Self-checking bench for the matrix multiply engine. Operand matrices are
// loaded under a series of dimension settings, multiplies are issued, and
// every result word is checked against a product computed inside the bench.
// Random gaps on the command side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_engine;
  import mme_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TARGET_WORDS  = 130;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] value;
    logic                     tail;
  } result_word_t;

  logic clk_i;
  logic rst_ni;

  mme_cfg_if cfg_if ();
  mme_in_if  in_if ();
  mme_out_if out_if ();

  matrix_multiply_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // bench-side copy of the engine's operand stores and dimension registers
  logic signed [ELEM_W-1:0] mat_a [MAX_DIM][MAX_DIM];
  logic signed [ELEM_W-1:0] mat_b [MAX_DIM][MAX_DIM];
  logic [CFG_W-1:0]         rows_a_reg;
  logic [CFG_W-1:0]         inner_reg;
  logic [CFG_W-1:0]         cols_b_reg;

  cmd_word_t    cmd_words_q [$];
  result_word_t product_q [$];

  // generator view of what the stores hold
  bit a_loaded [MAX_DIM][MAX_DIM];
  bit b_loaded [MAX_DIM][MAX_DIM];
  int gen_rows;
  int gen_inner;
  int gen_cols;

  int   words_queued;
  int   words_taken;
  int   effective_words;
  int   mismatches;
  int   idle_cycles;
  int   in_gap;
  int   out_stall;
  bit   calm;
  logic word_taken;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic int eff_dim(logic [CFG_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_DIM) return MAX_DIM;
    return int'(r);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [ELEM_W-1:0] pick_value();
    logic signed [ELEM_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        v = $urandom_range(0, 32'h0004_0000);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      8: v = 32'sh7FFF_FFFF;
      9: v = 32'sh8000_0000;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return CFG_W'($urandom_range(9, 15));
      2: return CFG_W'(MAX_DIM);
      default: return CFG_W'($urandom_range(1, 4));
    endcase
  endfunction

  // full product in row-major order, per-term floor shift, wide accumulate
  function automatic void compute_product();
    int     nr;
    int     nk;
    int     nc;
    longint acc;
    longint term;
    longint sum;
    longint vmax;
    longint vmin;
    result_word_t w;
    nr   = eff_dim(rows_a_reg);
    nk   = eff_dim(inner_reg);
    nc   = eff_dim(cols_b_reg);
    vmax = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
    vmin = -vmax - 1;
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        for (int k = 0; k < nk; k++) begin
          term = (longint'(mat_a[i][k]) * longint'(mat_b[k][j])) >>> FRACTION_BITS;
          sum  = acc + term;
          if (acc[63] == term[63] && sum[63] != acc[63]) begin
            sum = term[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
          end
          acc = sum;
        end
        if (acc > vmax) acc = vmax;
        if (acc < vmin) acc = vmin;
        w.row   = IDX_W'(i);
        w.col   = IDX_W'(j);
        w.value = acc[ELEM_W-1:0];
        w.tail  = (i == nr - 1) && (j == nc - 1);
        product_q.push_back(w);
      end
    end
  endfunction

  function automatic void push_word(logic [OP_W-1:0] op, int row, int col,
                                    logic signed [ELEM_W-1:0] v);
    cmd_word_t w;
    w.opcode = op;
    w.row    = IDX_W'(row);
    w.col    = IDX_W'(col);
    w.value  = v;
    cmd_words_q.push_back(w);
    words_queued++;
    if (op == OP_WRITE_A && row < gen_rows && col < gen_inner) begin
      a_loaded[row][col] = 1'b1;
      effective_words++;
    end
    if (op == OP_WRITE_B && row < gen_inner && col < gen_cols) begin
      b_loaded[row][col] = 1'b1;
      effective_words++;
    end
    if (op == OP_MULTIPLY) effective_words++;
  endfunction

  // fill every operand element the next multiply reads that is not yet loaded, then multiply
  function automatic void load_and_multiply();
    for (int i = 0; i < gen_rows; i++) begin
      for (int k = 0; k < gen_inner; k++) begin
        if (!a_loaded[i][k]) push_word(OP_WRITE_A, i, k, pick_value());
      end
    end
    for (int k = 0; k < gen_inner; k++) begin
      for (int j = 0; j < gen_cols; j++) begin
        if (!b_loaded[k][j]) push_word(OP_WRITE_B, k, j, pick_value());
      end
    end
    push_word(OP_MULTIPLY, $urandom_range(0, 7), $urandom_range(0, 7), $urandom());
  endfunction

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= val;
    @(posedge clk_i);
    while (!(cfg_if.valid && cfg_if.ready)) @(posedge clk_i);
  endtask

  task automatic set_dims(logic [CFG_W-1:0] r, logic [CFG_W-1:0] k, logic [CFG_W-1:0] c);
    write_reg(REG_ROWS_A, r);
    write_reg(REG_INNER_SIZE, k);
    write_reg(REG_COLS_B, c);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    gen_rows  = eff_dim(r);
    gen_inner = eff_dim(k);
    gen_cols  = eff_dim(c);
  endtask

  task automatic wait_idle();
    while (cmd_words_q.size() != 0 || words_taken != words_queued || product_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(logic [CFG_W-1:0] r, logic [CFG_W-1:0] k, logic [CFG_W-1:0] c);
    set_dims(r, k, c);
    calm = ($urandom_range(0, 4) == 0);
    repeat ($urandom_range(1, 3)) begin
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 9))
          0: push_word(OP_W'($urandom_range(0, 1)), $urandom_range(0, 7),
                       $urandom_range(0, 7), pick_value());
          1: push_word(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7), $urandom());
          2, 3, 4, 5: push_word(OP_WRITE_A, $urandom_range(0, gen_rows - 1),
                                $urandom_range(0, gen_inner - 1), pick_value());
          default: push_word(OP_WRITE_B, $urandom_range(0, gen_inner - 1),
                             $urandom_range(0, gen_cols - 1), pick_value());
        endcase
      end
      load_and_multiply();
    end
    wait_idle();
  endtask

  // command word driver
  always @(negedge clk_i) begin
    cmd_word_t w;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || word_taken) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_if.valid <= 1'b0;
      end else if (cmd_words_q.size() != 0) begin
        w = cmd_words_q.pop_front();
        in_if.valid      <= 1'b1;
        in_if.opcode     <= w.opcode;
        in_if.row_index  <= w.row;
        in_if.col_index  <= w.col;
        in_if.elem_value <= w.value;
        in_gap = pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      out_stall = out_stall - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_stall = pick_gap();
    end
  end

  // handshakes, prediction, checking and watchdog
  always @(posedge clk_i) begin
    bit           progress;
    result_word_t want;
    progress = 1'b0;
    word_taken <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        progress = 1'b1;
        case (cfg_if.reg_index)
          REG_ROWS_A:     rows_a_reg = cfg_if.wdata;
          REG_INNER_SIZE: inner_reg  = cfg_if.wdata;
          REG_COLS_B:     cols_b_reg = cfg_if.wdata;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        progress = 1'b1;
        words_taken++;
        case (in_if.opcode)
          OP_WRITE_A: begin
            if (in_if.row_index < eff_dim(rows_a_reg) && in_if.col_index < eff_dim(inner_reg))
              mat_a[in_if.row_index][in_if.col_index] = in_if.elem_value;
          end
          OP_WRITE_B: begin
            if (in_if.row_index < eff_dim(inner_reg) && in_if.col_index < eff_dim(cols_b_reg))
              mat_b[in_if.row_index][in_if.col_index] = in_if.elem_value;
          end
          OP_MULTIPLY: compute_product();
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        progress = 1'b1;
        if (product_q.size() == 0) begin
          $error("unexpected result word: row %0d col %0d value %h",
                 out_if.out_row, out_if.out_col, out_if.out_value);
          mismatches++;
        end else begin
          want = product_q.pop_front();
          if (out_if.out_row !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, out_if.out_row);
            mismatches++;
          end
          if (out_if.out_col !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, out_if.out_col);
            mismatches++;
          end
          if (out_if.out_value !== want.value) begin
            $error("out_value: expected %h, got %h", want.value, out_if.out_value);
            mismatches++;
          end
          if (out_if.out_last !== want.tail) begin
            $error("out_last: expected %0b, got %0b", want.tail, out_if.out_last);
            mismatches++;
          end
        end
      end
    end
    idle_cycles = progress ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.opcode     = OP_WRITE_A;
    in_if.row_index  = '0;
    in_if.col_index  = '0;
    in_if.elem_value = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = REG_ROWS_A;
    cfg_if.wdata     = '0;
    rows_a_reg       = DIM_RESET;
    inner_reg        = DIM_RESET;
    cols_b_reg       = DIM_RESET;
    gen_rows         = MAX_DIM;
    gen_inner        = MAX_DIM;
    gen_cols         = MAX_DIM;
    words_queued     = 0;
    words_taken      = 0;
    effective_words  = 0;
    mismatches       = 0;
    idle_cycles      = 0;
    in_gap           = 0;
    out_stall        = 0;
    calm             = 1'b0;
    word_taken       = 1'b0;
    rst_ni           = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // 1x1 product: saturation both ways, ignored writes, unused opcode
    set_dims(1, 1, 1);
    push_word(OP_WRITE_A, 0, 0, 32'sh7FFF_FFFF);
    push_word(OP_WRITE_B, 0, 0, 32'sh7FFF_FFFF);
    push_word(OP_MULTIPLY, 0, 0, '0);
    push_word(OP_WRITE_B, 0, 0, 32'sh8000_0000);
    push_word(OP_MULTIPLY, 7, 7, 32'shFFFF_FFFF);
    push_word(OP_WRITE_A, 1, 0, '0);
    push_word(OP_WRITE_B, 0, 1, '0);
    push_word(OP_WRITE_A, 7, 7, 32'sh0000_007B);
    push_word(OP_UNUSED, 7, 7, 32'shFFFF_FFFF);
    push_word(OP_WRITE_A, 0, 0, 32'sh8000_0000);
    push_word(OP_MULTIPLY, 3, 4, '0);
    // tiny negative product: smallest negative value times 1.0, exact after the fraction shift
    push_word(OP_WRITE_A, 0, 0, 32'shFFFF_FFFF);
    push_word(OP_WRITE_B, 0, 0, 32'sh0001_0000);
    push_word(OP_MULTIPLY, 0, 0, '0);
    wait_idle();

    // oversize and zero registers clamp to 8 rows, 1 inner, 1 column
    set_dims(15, 0, 1);
    load_and_multiply();
    wait_idle();

    run_phase(0, CFG_W'($urandom_range(8, 15)), 1);
    while (effective_words < TARGET_WORDS) run_phase(pick_dim(), pick_dim(), pick_dim());

    wait_idle();
    if (mismatches == 0 && product_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/mme_pkg.sv
rtl/core/mme_if.sv
rtl/core/mme_ram.sv
rtl/core/mme_ctrl.sv
rtl/core/mme_dp.sv
rtl/core/matrix_multiply_engine.sv
verif/tb_matrix_multiply_engine.sv
